/* sv/brr_pkg.sv */
// shared types and codes for the bitmap row to rgb565 decoder
`timescale 1ns / 1ps

package brr_pkg;

  // pixel depth codes of the depth_mode register
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_16BPP = 3'd3;
  localparam logic [2:0] MODE_24BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;
  // unknown depths, bytes are swallowed
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  // configuration register indexes
  localparam logic REG_DEPTH_MODE  = 1'b0;
  localparam logic REG_IMAGE_WIDTH = 1'b1;

  // input word kinds
  localparam logic ACT_PAL  = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  typedef enum logic [1:0] {
    CMD_PAL_WR,
    CMD_INDEX,
    CMD_DIRECT
  } cmd_kind_t;

  // one command from front to back: a palette write or a run of pixels
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  mode;
    logic [15:0] data;
    logic [7:0]  pal_index;
    logic [3:0]  count;
    logic        row_last;
  } cmd_t;

endpackage

/* sv/brr_front.sv */
// front end: takes words, tracks the row position and builds pixel commands
`timescale 1ns / 1ps

module brr_front #(
  parameter int DISPLAY_WIDTH = 160
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data,
  input  logic          push,
  output logic          full,
  input  logic          action,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    palette_index,
  input  logic [7:0]    palette_red,
  input  logic [7:0]    palette_green,
  input  logic [7:0]    palette_blue,
  input  logic          q_full,
  output logic          q_push,
  output brr_pkg::cmd_t q_data
);
  import brr_pkg::*;

  localparam logic [12:0] DispW = 13'(DISPLAY_WIDTH);

  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  logic [2:0]  depth_mode;
  logic [12:0] image_width;
  logic [14:0] row_byte_count;
  logic [12:0] row_pixel_count;
  logic [23:0] pending_bytes;
  logic [1:0]  byte_phase;

  logic        accept;
  logic [15:0] wx;
  logic [15:0] data_len;
  logic [15:0] row_len;
  logic        row_ok;
  logic        in_data;
  logic        is_pal;
  logic        phase_last;
  logic [15:0] direct_pix;
  logic [3:0]  slots;
  logic [12:0] top;
  logic [12:0] rem_w;
  logic [12:0] rem_t;
  logic [3:0]  n_valid;
  logic [3:0]  n_vis;
  logic        row_last_hit;
  logic        last_byte;

  assign wx = {3'b000, image_width};

  always_comb begin
    case (depth_mode)
      MODE_1BPP:  data_len = (wx + 16'd7) >> 3;
      MODE_4BPP:  data_len = (wx + 16'd1) >> 1;
      MODE_8BPP:  data_len = wx;
      MODE_16BPP: data_len = wx << 1;
      MODE_24BPP: data_len = wx + (wx << 1);
      MODE_32BPP: data_len = wx << 2;
      default:    data_len = '0;
    endcase
  end

  assign row_len = (data_len + 16'd3) & ~16'd3;
  assign row_ok  = (depth_mode <= MODE_32BPP) && (row_len != 16'd0);
  assign in_data = {1'b0, row_byte_count} < data_len;
  assign is_pal  = depth_mode <= MODE_8BPP;

  always_comb begin
    case (depth_mode)
      MODE_16BPP: phase_last = byte_phase == 2'd1;
      MODE_24BPP: phase_last = byte_phase == 2'd2;
      default:    phase_last = byte_phase == 2'd3;
    endcase
  end

  always_comb begin
    case (depth_mode)
      MODE_16BPP: direct_pix = {data_byte, pending_bytes[7:0]};
      MODE_24BPP: direct_pix = pack565(data_byte, pending_bytes[15:8], pending_bytes[7:0]);
      default:    direct_pix = pack565(pending_bytes[23:16], pending_bytes[15:8],
                                       pending_bytes[7:0]);
    endcase
  end

  // pixel slots this word fills
  always_comb begin
    if (!in_data) begin
      slots = 4'd0;
    end else begin
      case (depth_mode)
        MODE_1BPP: slots = 4'd8;
        MODE_4BPP: slots = 4'd2;
        MODE_8BPP: slots = 4'd1;
        default:   slots = phase_last ? 4'd1 : 4'd0;
      endcase
    end
  end

  assign top   = (image_width < DispW) ? image_width : DispW;
  assign rem_w = image_width - row_pixel_count;
  assign rem_t = top - row_pixel_count;

  always_comb begin
    if (row_pixel_count < image_width) begin
      n_valid = (rem_w < {9'b0, slots}) ? rem_w[3:0] : slots;
    end else begin
      n_valid = 4'd0;
    end
    // visible pixels are always a prefix of the valid ones
    if (row_pixel_count < top) begin
      n_vis = (rem_t < {9'b0, slots}) ? rem_t[3:0] : slots;
    end else begin
      n_vis = 4'd0;
    end
  end

  assign row_last_hit = (row_pixel_count + {9'b0, n_vis}) == top;
  assign last_byte    = ({1'b0, row_byte_count} + 16'd1) >= row_len;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && ((action == ACT_PAL) || (row_ok && n_vis != 4'd0));

  always_comb begin
    q_data.kind      = (action == ACT_PAL) ? CMD_PAL_WR : (is_pal ? CMD_INDEX : CMD_DIRECT);
    q_data.mode      = depth_mode;
    q_data.pal_index = palette_index;
    q_data.count     = n_vis;
    q_data.row_last  = row_last_hit;
    if (action == ACT_PAL) begin
      q_data.data = pack565(palette_red, palette_green, palette_blue);
    end else if (is_pal) begin
      q_data.data = {8'b0, data_byte};
    end else begin
      q_data.data = direct_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode      <= MODE_8BPP;
      image_width     <= 13'd1;
      row_byte_count  <= '0;
      row_pixel_count <= '0;
      pending_bytes   <= '0;
      byte_phase      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEPTH_MODE) begin
        depth_mode <= cfg_data[2:0];
      end else if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      row_byte_count  <= '0;
      row_pixel_count <= '0;
      pending_bytes   <= '0;
      byte_phase      <= '0;
    end else if (accept && (action == ACT_BYTE) && row_ok) begin
      if (last_byte) begin
        row_byte_count  <= '0;
        row_pixel_count <= '0;
        pending_bytes   <= '0;
        byte_phase      <= '0;
      end else begin
        row_byte_count  <= row_byte_count + 15'd1;
        row_pixel_count <= row_pixel_count + {9'b0, n_valid};
        if (in_data && !is_pal) begin
          if (phase_last) begin
            byte_phase    <= '0;
            pending_bytes <= '0;
          end else begin
            byte_phase <= byte_phase + 2'd1;
            case (byte_phase)
              2'd0:    pending_bytes <= {16'b0, data_byte};
              2'd1:    pending_bytes[15:8] <= data_byte;
              2'd2:    pending_bytes[23:16] <= data_byte;
              default: pending_bytes <= pending_bytes;
            endcase
          end
        end
      end
    end
  end

endmodule

/* sv/brr_cmd_fifo.sv */
// short command queue between front and back
`timescale 1ns / 1ps

module brr_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  brr_pkg::cmd_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output brr_pkg::cmd_t rd_data,
  output logic          q_empty
);
  import brr_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;

  assign q_full  = count == (PtrW + 1)'(Depth);
  assign q_empty = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (PtrW + 1)'(wr_en) - (PtrW + 1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* sv/brr_back.sv */
// back end: palette memory, result queue, one pixel a cycle while it has room
`timescale 1ns / 1ps

module brr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  brr_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output logic [15:0]   pixel_rgb565,
  output logic          row_last,
  output logic          item_last
);
  import brr_pkg::*;

  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);

  typedef struct packed {
    logic [15:0] pix;
    logic        row_last;
    logic        item_last;
  } pix_t;

  logic [15:0]        pal_mem [256];
  pix_t               out_mem [OutDepth];

  cmd_t               cur;
  logic               cur_valid;
  logic [2:0]         k;
  logic               s1_valid;
  logic               s1_direct;
  logic [15:0]        s1_pix;
  logic               s1_row_last;
  logic               s1_item_last;
  logic [15:0]        pal_rdata;
  logic [OutPtrW-1:0] out_wr_ptr;
  logic [OutPtrW-1:0] out_rd_ptr;
  logic [OutPtrW:0]   out_count;

  logic               issue;
  logic               pix_last;
  logic               load_ok;
  logic               out_pop;
  logic [7:0]         rd_addr;
  pix_t               s1_word;

  // room for the word in flight and the new one
  assign issue    = cur_valid &&
                    ((out_count + {{OutPtrW{1'b0}}, s1_valid}) < (OutPtrW + 1)'(OutDepth));
  assign pix_last = ({1'b0, k} + 4'd1) == cur.count;
  assign load_ok  = !cur_valid || (issue && pix_last);
  assign q_pop    = load_ok && !q_empty;

  always_comb begin
    case (cur.mode)
      MODE_1BPP: rd_addr = {7'b0, cur.data[3'd7 - k]};
      MODE_4BPP: rd_addr = (k == 3'd0) ? {4'b0, cur.data[7:4]} : {4'b0, cur.data[3:0]};
      default:   rd_addr = cur.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      k         <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (q_pop && q_head.kind != CMD_PAL_WR) begin
        cur_valid <= 1'b1;
        k         <= '0;
      end else if (load_ok) begin
        cur_valid <= 1'b0;
      end else if (issue) begin
        k <= k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind != CMD_PAL_WR) begin
      cur <= q_head;
    end
    if (issue) begin
      s1_direct    <= cur.kind == CMD_DIRECT;
      s1_pix       <= cur.data;
      s1_row_last  <= pix_last && cur.row_last;
      s1_item_last <= pix_last;
    end
  end

  // palette: read for a lookup, written in command order
  always_ff @(posedge clk) begin
    if (issue) begin
      pal_rdata <= pal_mem[rd_addr];
    end
    if (q_pop && q_head.kind == CMD_PAL_WR) begin
      pal_mem[q_head.pal_index] <= q_head.data;
    end
  end

  assign s1_word.pix       = s1_direct ? s1_pix : pal_rdata;
  assign s1_word.row_last  = s1_row_last;
  assign s1_word.item_last = s1_item_last;

  assign empty        = out_count == '0;
  assign out_pop      = pop && !empty;
  assign pixel_rgb565 = out_mem[out_rd_ptr].pix;
  assign row_last     = out_mem[out_rd_ptr].row_last;
  assign item_last    = out_mem[out_rd_ptr].item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      if (s1_valid) begin
        out_wr_ptr <= out_wr_ptr + OutPtrW'(1);
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + OutPtrW'(1);
      end
      out_count <= out_count + (OutPtrW + 1)'(s1_valid) - (OutPtrW + 1)'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_mem[out_wr_ptr] <= s1_word;
    end
  end

  a_out_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> out_count < (OutPtrW + 1)'(OutDepth))
    else $error("result queue overflow");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, k} < cur.count))
    else $error("pixel counter past command length");

  a_pal_order: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == CMD_PAL_WR) |-> (!cur_valid || (issue && pix_last)))
    else $error("palette write overtook a pending lookup");

endmodule

/* sv/bmp_row_to_rgb565.sv */
// top level of the bitmap row to rgb565 decoder
`timescale 1ns / 1ps

// Input channel: push/full. Each word is either a palette write (action 0:
// palette_index and an rgb color, stored as rgb565) or one byte of bitmap
// row data (action 1) including the padding up to four bytes.
// Result channel: empty/pop. Each word is one rgb565 pixel; row_last marks
// the last visible pixel of a row, item_last the last pixel of a byte.
// Config: cfg_we writes cfg_data into register cfg_index (0 depth_mode,
// 1 image_width) and returns the row position to its start.
// Path: a byte's pixels pass through the command queue, the current
// command register and the s1 register into the result queue.
// Throughput: the front takes one word per cycle while the command queue
// has room. The back end emits one pixel per cycle through the single
// palette read port while the result queue has room; a byte yields up
// to 8 visible pixels at 1 bpp, 2 at 4 bpp, 1 otherwise. Bytes with no
// visible pixel never reach it, and a palette write is stored as it is popped.
// A 4-deep command queue lets the front take bytes while pixels drain.
// Reset clears row position, queues and sets 8 bpp, width 1; palette
// contents stay undefined until written. When pop is held low the result
// queue fills, the back end stops, then the command queue fills and full
// rises; nothing is lost.
module bmp_row_to_rgb565 #(
  parameter int DISPLAY_WIDTH = 160
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pixel_rgb565,
  output logic        row_last,
  output logic        item_last
);
  import brr_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_wr_data;
  cmd_t q_head;

  brr_front #(
    .DISPLAY_WIDTH(DISPLAY_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .action        (action),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wr_data)
  );

  brr_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty)
  );

  brr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .pixel_rgb565 (pixel_rgb565),
    .row_last     (row_last),
    .item_last    (item_last)
  );

endmodule
